// File: src/tsp_pkg.sv
// Shared types, constants and helpers for the telemetry sensor poll responder.
package tsp_pkg;

  localparam int unsigned VALUE_W = 24;
  localparam int unsigned UNIT_W  = 4;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned PROD_W  = 49;

  // Reciprocals for exact truncating division of a 24-bit magnitude.
  localparam logic [24:0] RECIP_TEN  = 25'd13421773;
  localparam int unsigned SHIFT_TEN  = 27;
  localparam logic [24:0] RECIP_THOU = 25'd17179870;
  localparam int unsigned SHIFT_THOU = 34;

  localparam logic [VALUE_W-1:0] MAG_MAX = 24'd16383;

  typedef enum logic [1:0] {
    SCALE_ONE,
    SCALE_TEN,
    SCALE_THOU
  } scale_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_FIX,
    BK_HOLD
  } back_state_e;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] raw;
    logic [UNIT_W-1:0]  unit;
    logic               alarm;
    scale_e             scale;
  } poll_job_t;

  function automatic scale_e scale_of(input logic [UNIT_W-1:0] unit);
    scale_e s;
    case (unit) inside
      4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd7, 4'd13: s = SCALE_ONE;
      4'd5:                                      s = SCALE_THOU;
      default:                                   s = SCALE_TEN;
    endcase
    return s;
  endfunction

endpackage

// File: src/tsp_if.sv
// Handshake interfaces for the input and result channels.
interface tsp_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [3:0]         slot_index;
  logic signed [23:0] value_tenths;
  logic [3:0]         unit_code;
  logic               alarm_bit;
  logic [7:0]         poll_byte;
  logic               poll_alone;

  modport source (
    output valid, op, slot_index, value_tenths, unit_code, alarm_bit, poll_byte, poll_alone,
    input  ready
  );
  modport sink (
    input  valid, op, slot_index, value_tenths, unit_code, alarm_bit, poll_byte, poll_alone,
    output ready
  );
endinterface

interface tsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] address_unit_byte;
  logic [7:0] value_low_byte;
  logic [7:0] value_high_byte;

  modport source (
    output valid, address_unit_byte, value_low_byte, value_high_byte,
    input  ready
  );
  modport sink (
    input  valid, address_unit_byte, value_low_byte, value_high_byte,
    output ready
  );
endinterface

// File: src/telemetry_sensor_poll_responder_unit.sv
// Top level of the telemetry sensor poll responder.
// An update word is written into the slot store at the edge that accepts it.
// An answered poll passes through the queue and then the load, multiply and pack registers before
// the reply valid rises. The back part handles one reply at a time, so it takes no new job until
// the last reply word is taken. Input ready is low only while the
// two-entry queue is full. Reset is asynchronous and active low: the store reads as zero and
// the skip counter clears.
module telemetry_sensor_poll_responder_unit import tsp_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tsp_in_if.sink    in_i,
  tsp_out_if.source out_o
);

  // The front part writes the slot store and decides which polls are answered. For an
  // answered poll it takes a snapshot of the addressed slot, so later updates to that slot
  // cannot alter a reply that is still waiting in the queue.
  logic      push;
  poll_job_t push_job;
  logic      full;

  // The back part drains the queue one job at a time. It turns the stored tenths into a magnitude,
  // divides by ten or a thousand through a reciprocal multiply when the unit calls for it, saturates
  // and packs the three reply bytes into an output register that holds until the word is taken.
  logic      pop;
  logic      empty;
  poll_job_t pop_job;

  tsp_front #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .push_o     (push),
    .push_job_o (push_job),
    .full_i     (full)
  );

  // Two entries let the front keep taking words while a reply stalls, until both are filled.
  tsp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_job_o  (pop_job)
  );

  tsp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .job_i   (pop_job),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// File: src/tsp_queue.sv
// Two-entry queue of poll jobs between the front and back parts.
module tsp_queue import tsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  poll_job_t push_job_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output poll_job_t pop_job_o
);

  poll_job_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o    = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign pop_job_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("Queue pushed while full.");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("Queue popped while empty.");
`endif

endmodule

// File: src/tsp_front.sv
// Front part: accepts words, keeps the slot store and the skip counter, queues answers.
module tsp_front import tsp_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tsp_in_if.sink    in_i,
  output logic      push_o,
  output poll_job_t push_job_o,
  input  logic      full_i
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [ADDR_W:0] SLOT_LIM = (ADDR_W + 1)'(SLOT_COUNT);

  logic [VALUE_W-1:0]    value_q [SLOT_COUNT];
  logic [UNIT_W-1:0]     unit_q  [SLOT_COUNT];
  logic                  alarm_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] filled_q, filled_d;
  logic [1:0]            skip_q, skip_d;

  logic             accept;
  logic             upd_hit;
  logic             answered;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_hit;

  assign in_i.ready = ~full_i;
  assign accept     = in_i.valid & in_i.ready;
  assign wr_idx     = in_i.slot_index[IDX_W-1:0];
  assign rd_idx     = in_i.poll_byte[IDX_W-1:0];
  assign upd_hit    = accept & ~in_i.op & ({1'b0, in_i.slot_index} < SLOT_LIM);
  assign answered   = accept & in_i.op & (skip_q == 2'd3) & in_i.poll_alone
                    & (in_i.poll_byte[7:4] == 4'd0);
  assign rd_hit     = ({1'b0, in_i.poll_byte[3:0]} < SLOT_LIM) && filled_q[rd_idx];

  always_comb begin
    push_o           = answered;
    push_job_o.addr  = in_i.poll_byte[3:0];
    push_job_o.raw   = rd_hit ? value_q[rd_idx] : '0;
    push_job_o.unit  = rd_hit ? unit_q[rd_idx] : '0;
    push_job_o.alarm = rd_hit ? alarm_q[rd_idx] : 1'b0;
    push_job_o.scale = scale_of(push_job_o.unit);

    filled_d = filled_q;
    if (upd_hit) begin
      filled_d[wr_idx] = 1'b1;
    end

    skip_d = skip_q;
    if (accept && in_i.op) begin
      if (answered) begin
        skip_d = 2'd1;
      end else if (skip_q != 2'd3) begin
        skip_d = skip_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
      skip_q   <= 2'd0;
    end else begin
      filled_q <= filled_d;
      skip_q   <= skip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_hit) begin
      value_q[wr_idx] <= $unsigned(in_i.value_tenths);
      unit_q[wr_idx]  <= in_i.unit_code;
      alarm_q[wr_idx] <= in_i.alarm_bit;
    end
  end

`ifndef NO_ASSERTIONS
  a_skip_after_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    answered |=> (skip_q == 2'd1)) else $error("Skip counter not at one after an answer.");
`endif

endmodule

// File: src/tsp_back.sv
// Back part: scales a queued poll job and holds the reply word until it is taken.
module tsp_back import tsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  poll_job_t job_i,
  output logic      pop_o,
  tsp_out_if.source out_o
);

  back_state_e state_q, state_d;

  logic [VALUE_W-1:0] mag_q, mag_d;
  logic               neg_q;
  scale_e             scale_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [UNIT_W-1:0]  unit_q;
  logic               alarm_q;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [7:0]         au_q, lo_q, hi_q;

  logic [VALUE_W-1:0] quo;
  logic [13:0]        sat;
  logic               sign;

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = BK_MUL;
        end
      end
      BK_MUL:  state_d = BK_FIX;
      BK_FIX:  state_d = BK_HOLD;
      BK_HOLD: begin
        if (out_o.ready) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    mag_d = job_i.raw[VALUE_W-1] ? (~job_i.raw + 24'd1) : job_i.raw;

    case (scale_q)
      SCALE_TEN:  prod_d = PROD_W'(mag_q) * PROD_W'(RECIP_TEN);
      SCALE_THOU: prod_d = PROD_W'(mag_q) * PROD_W'(RECIP_THOU);
      default:    prod_d = PROD_W'(mag_q);
    endcase

    case (scale_q)
      SCALE_TEN:  quo = VALUE_W'(prod_q >> SHIFT_TEN);
      SCALE_THOU: quo = VALUE_W'(prod_q >> SHIFT_THOU);
      default:    quo = VALUE_W'(prod_q);
    endcase

    sat  = (quo > MAG_MAX) ? MAG_MAX[13:0] : quo[13:0];
    sign = neg_q && (quo != '0);
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mag_q   <= mag_d;
      neg_q   <= job_i.raw[VALUE_W-1];
      scale_q <= job_i.scale;
      addr_q  <= job_i.addr;
      unit_q  <= job_i.unit;
      alarm_q <= job_i.alarm;
    end
    if (state_q == BK_MUL) begin
      prod_q <= prod_d;
    end
    if (state_q == BK_FIX) begin
      au_q <= {addr_q, unit_q};
      lo_q <= {sat[6:0], alarm_q};
      hi_q <= {sign, sat[13:7]};
    end
  end

  assign out_o.valid             = (state_q == BK_HOLD);
  assign out_o.address_unit_byte = au_q;
  assign out_o.value_low_byte    = lo_q;
  assign out_o.value_high_byte   = hi_q;

`ifndef NO_ASSERTIONS
  a_sign_needs_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.value_high_byte[7]) |->
      ((out_o.value_high_byte[6:0] != 7'd0) || (out_o.value_low_byte[7:1] != 7'd0)))
    else $error("Negative sign sent with zero magnitude.");
`endif

endmodule
